>>> sv/fag_pkg.sv
// ----------------------------------------------------------------------------
// fag_pkg: shared types and constants for the frame autoscale gray core
// Frame geometry, pointer widths, command codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fag_pkg;

  // Frame geometry
  localparam int FRAME_WIDTH  = 160;
  localparam int FRAME_HEIGHT = 120;
  localparam int PIXELS       = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int PTR_W        = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam logic [PTR_W-1:0] LAST_PIX = PTR_W'(PIXELS - 1);

  // Pixel and gray widths
  localparam int BYTE_W = 8;
  localparam int PIX_W  = 2 * BYTE_W;
  localparam int GRAY_W = 8;
  localparam int PROD_W = PIX_W + GRAY_W;
  localparam logic [GRAY_W-1:0] GRAY_SPAN = GRAY_W'(254);
  localparam logic [PIX_W-1:0]  PIXEL_MAX = {PIX_W{1'b1}};

  // Restoring divider: one quotient bit per step
  localparam int DIV_STEPS = GRAY_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

  // Beat command codes
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_PREP,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // input beat taken this cycle
    logic prep;     // form difference and special cases
    logic mul;      // scale by span, seed divider
    logic step;     // one divider step
    logic emit;     // load output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic readout;  // complete frame available
    logic out_free; // output register can take a result
  } dp_stat_t;

endpackage

>>> sv/frame_autoscale_gray_core.sv
// ----------------------------------------------------------------------------
// frame_autoscale_gray_core: min/max contrast stretch of one thermal frame
// Loads a frame of 16-bit pixels, then reads it out scaled to 0..254.
// ----------------------------------------------------------------------------
// A load beat (tuser 0) sends the pixel to the frame memory and updates
// the running min/max; loads during readout are dropped. After the last
// pixel of the frame, readout opens. A read beat (tuser 1) keeps in_tready
// low until its result is loaded into the output register. It passes the
// memory fetch at the accepting edge, one difference stage, one scaling
// multiply, eight steps of a radix-2 restoring divider that yields
// floor((v-min)*254/range), and the output load. A read before the frame
// is complete returns gray 0 with tuser low and goes straight to the
// output load. The result waits in an output register, so the next beat
// is taken while it is unread; the output load of a later read stalls for
// as long as that register still holds an unread beat. The frame memory
// needs no clearing pass after reset.
module frame_autoscale_gray_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] high_byte, [15:8] low_byte
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] gray_level
  output logic        out_tlast,
  output logic        out_tuser   // [0] ready_res
);
  import fag_pkg::*;

  dp_cmd_t  dcmd;
  dp_stat_t dstat;
  cmd_t     in_cmd;

  assign in_cmd = cmd_t'(in_tuser);

  fag_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_cmd),
    .in_tready (in_tready),
    .stat      (dstat),
    .cmd       (dcmd)
  );

  fag_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (dcmd),
    .stat          (dstat),
    .in_cmd        (in_cmd),
    .high_byte     (in_tdata[BYTE_W-1:0]),
    .low_byte      (in_tdata[2*BYTE_W-1:BYTE_W]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_gray      (out_tdata),
    .out_last      (out_tlast),
    .out_ready_res (out_tuser)
  );

  // A read beat keeps the core busy for the following cycle
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == CMD_READ) |=> !in_tready)
    else $error("core took a beat right after a read");

  // A read without a frame gives gray 0
  a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0 && !out_tlast))
    else $error("not-ready result carries data");

  // Gray level stays within the span
  a_gray_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata <= GRAY_SPAN))
    else $error("gray level above span");

endmodule

>>> sv/fag_ctrl.sv
// ----------------------------------------------------------------------------
// fag_ctrl: sequencing controller
// Accepts beats while idle and walks a read through fetch, prep, the divider
// steps and the output load, or straight to the load if no frame is complete.
// ----------------------------------------------------------------------------
module fag_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  fag_pkg::cmd_t     in_cmd,
  output logic              in_tready,
  input  fag_pkg::dp_stat_t stat,
  output fag_pkg::dp_cmd_t  cmd
);
  import fag_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              fire;

  assign fire = in_tvalid && (state_r == ST_IDLE);

  // State and step counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (fire && in_cmd == CMD_READ) begin
          state_nxt = stat.readout ? ST_FETCH : ST_EMIT;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        state_nxt = ST_DIVIDE;
        cnt_nxt   = '0;
      end
      ST_DIVIDE: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = fire;
      end
      ST_FETCH:  cmd.prep = 1'b1;
      ST_PREP:   cmd.mul  = 1'b1;
      ST_DIVIDE: cmd.step = 1'b1;
      ST_EMIT:   cmd.emit = stat.out_free;
      default:   cmd      = '0;
    endcase
  end

endmodule

>>> sv/fag_dp.sv
// ----------------------------------------------------------------------------
// fag_dp: datapath
// Frame memory, running min/max, pointers, scaling multiply, restoring
// divider and the output register.
// ----------------------------------------------------------------------------
module fag_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fag_pkg::dp_cmd_t                 cmd,
  output fag_pkg::dp_stat_t                stat,
  input  fag_pkg::cmd_t                    in_cmd,
  input  logic [fag_pkg::BYTE_W-1:0]       high_byte,
  input  logic [fag_pkg::BYTE_W-1:0]       low_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fag_pkg::GRAY_W-1:0]       out_gray,
  output logic                             out_last,
  output logic                             out_ready_res
);
  import fag_pkg::*;

  // Frame memory
  logic [PIX_W-1:0] frame_mem [PIXELS];
  logic [PIX_W-1:0] rd_data_r;

  // Frame statistics and pointers
  logic [PIX_W-1:0] run_min_r, run_max_r;
  logic [PIX_W-1:0] lat_min_r, lat_rng_r;
  logic [PTR_W-1:0] load_ptr_r, read_ptr_r;
  logic             phase_r;

  // Per-read state
  logic             ready_r, last_r;
  logic [PIX_W-1:0] diff_r;
  logic             zero_r, sat_r;
  logic [PIX_W-1:0] rem_r;
  logic [GRAY_W-1:0] quo_r;

  // Output register
  logic              out_valid_r;
  logic [GRAY_W-1:0] out_gray_r;
  logic              out_last_r, out_ready_res_r;

  logic [PIX_W-1:0]  pix, new_min, new_max;
  logic              wr_en, rd_en;
  logic [PROD_W-1:0] prod;
  logic [PIX_W:0]    trial;
  logic              trial_ge;

  assign pix     = {high_byte, low_byte};
  assign new_min = (pix < run_min_r) ? pix : run_min_r;
  assign new_max = (pix > run_max_r) ? pix : run_max_r;
  assign wr_en   = cmd.accept && in_cmd == CMD_LOAD && !phase_r;
  assign rd_en   = cmd.accept && in_cmd == CMD_READ && phase_r;

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[load_ptr_r] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= frame_mem[read_ptr_r];
    end
  end

  // Statistics, pointers and phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_min_r  <= PIXEL_MAX;
      run_max_r  <= '0;
      lat_min_r  <= '0;
      lat_rng_r  <= '0;
      load_ptr_r <= '0;
      read_ptr_r <= '0;
      phase_r    <= 1'b0;
    end else if (wr_en) begin
      if (load_ptr_r == LAST_PIX) begin
        lat_min_r  <= new_min;
        lat_rng_r  <= new_max - new_min;
        run_min_r  <= PIXEL_MAX;
        run_max_r  <= '0;
        load_ptr_r <= '0;
        read_ptr_r <= '0;
        phase_r    <= 1'b1;
      end else begin
        run_min_r  <= new_min;
        run_max_r  <= new_max;
        load_ptr_r <= load_ptr_r + PTR_W'(1);
      end
    end else if (rd_en) begin
      if (read_ptr_r == LAST_PIX) begin
        read_ptr_r <= '0;
        phase_r    <= 1'b0;
      end else begin
        read_ptr_r <= read_ptr_r + PTR_W'(1);
      end
    end
  end

  // Result flags captured at the read beat
  always_ff @(posedge clk) begin
    if (cmd.accept && in_cmd == CMD_READ) begin
      ready_r <= phase_r;
      last_r  <= phase_r && (read_ptr_r == LAST_PIX);
    end
  end

  // Difference and special cases: flat frame or below min gives 0,
  // difference at or above range saturates at the span
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      diff_r <= rd_data_r - lat_min_r;
      zero_r <= (lat_rng_r == '0) || (rd_data_r < lat_min_r);
      sat_r  <= (rd_data_r - lat_min_r) >= lat_rng_r;
    end
  end

  // Scale and divide: quotient is below 256 here, so the upper product
  // bits seed the remainder and the low bits shift in one per step
  assign prod     = PROD_W'(diff_r) * PROD_W'(GRAY_SPAN);
  assign trial    = {rem_r, quo_r[GRAY_W-1]};
  assign trial_ge = trial >= {1'b0, lat_rng_r};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem_r <= prod[PROD_W-1:GRAY_W];
      quo_r <= prod[GRAY_W-1:0];
    end else if (cmd.step) begin
      rem_r <= trial_ge ? PIX_W'(trial - {1'b0, lat_rng_r}) : trial[PIX_W-1:0];
      quo_r <= {quo_r[GRAY_W-2:0], trial_ge};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      priority if (!ready_r || zero_r) begin
        out_gray_r <= '0;
      end else if (sat_r) begin
        out_gray_r <= GRAY_SPAN;
      end else begin
        out_gray_r <= quo_r;
      end
      out_last_r      <= last_r;
      out_ready_res_r <= ready_r;
    end
  end

  assign stat.readout  = phase_r;
  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_gray      = out_gray_r;
  assign out_last      = out_last_r;
  assign out_ready_res = out_ready_res_r;

endmodule

>>> tb/tb_frame_autoscale_gray_core.sv
// ----------------------------------------------------------------------------
// tb_frame_autoscale_gray_core: self-checking bench for the autoscale core
// Streams whole frames of 16-bit pixels into the core, then reads them back
// and checks each gray level against an in-bench contrast-stretch predictor.
// It covers reads before a frame is complete, a flat frame, a full-scale
// frame and a narrow-range frame, with loads dropped during readout and
// random idle cycles on both sides of the stream.
// ----------------------------------------------------------------------------
module tb_frame_autoscale_gray_core;
  import fag_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One expected output beat
  typedef struct {
    logic [GRAY_W-1:0] gray;
    logic              last;
    logic              ready;
  } gray_beat_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // [7:0] high_byte, [15:8] low_byte
  logic        in_tuser   = 1'b0; // [0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [7:0] gray_level
  logic        out_tlast;
  logic        out_tuser;         // [0] ready_res

  // Predictor state
  logic [PIX_W-1:0] frame_mem [PIXELS];
  logic [PIX_W-1:0] run_min    = PIXEL_MAX;
  logic [PIX_W-1:0] run_max    = '0;
  logic [PIX_W-1:0] lat_min    = '0;
  logic [PIX_W-1:0] lat_range  = '0;
  int               load_idx   = 0;
  int               read_idx   = 0;
  bit               readout_open = 1'b0;

  gray_beat_t expected_grays[$];

  // Bookkeeping
  int  mismatches    = 0;
  int  loads_taken   = 0;
  int  loads_dropped = 0;
  int  reads_taken   = 0;
  int  frames_read   = 0;
  int  beats_sent    = 0;
  int  grays_checked = 0;
  bit  src_burst     = 1'b0;
  bit  sink_burst    = 1'b0;

  frame_autoscale_gray_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Contrast stretch of one stored pixel
  function automatic logic [GRAY_W-1:0] stretch_gray(logic [PIX_W-1:0] pix);
    int unsigned q;
    if (lat_range == '0 || pix < lat_min) return '0;
    q = ((int'(pix) - int'(lat_min)) * 254) / int'(lat_range);
    if (q > 254) q = 254;
    return q[GRAY_W-1:0];
  endfunction

  // Update the predictor with one accepted beat
  function automatic void predict_beat(cmd_t cmd, logic [PIX_W-1:0] pix);
    gray_beat_t exp_beat;
    if (cmd == CMD_LOAD) begin
      if (readout_open) begin
        loads_dropped++;
        return;
      end
      loads_taken++;
      frame_mem[load_idx] = pix;
      if (pix < run_min) run_min = pix;
      if (pix > run_max) run_max = pix;
      load_idx++;
      if (load_idx >= PIXELS) begin
        lat_min      = run_min;
        lat_range    = run_max - run_min;
        run_min      = PIXEL_MAX;
        run_max      = '0;
        load_idx     = 0;
        read_idx     = 0;
        readout_open = 1'b1;
      end
      return;
    end
    reads_taken++;
    if (!readout_open) begin
      exp_beat = '{gray: '0, last: 1'b0, ready: 1'b0};
    end else begin
      exp_beat = '{gray: stretch_gray(frame_mem[read_idx]), last: 1'b0, ready: 1'b1};
      if (read_idx == PIXELS - 1) begin
        exp_beat.last = 1'b1;
        read_idx      = 0;
        readout_open  = 1'b0;
        frames_read++;
      end else begin
        read_idx++;
      end
    end
    expected_grays.push_back(exp_beat);
  endfunction

  // Drive one beat and wait for the core to take it
  task automatic send_beat(input cmd_t cmd, input logic [PIX_W-1:0] pix);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {pix[7:0], pix[15:8]};
    do @(posedge clk); while (!in_tready);
    predict_beat(cmd, pix);
    beats_sent++;
    if (beats_sent % 256 == 0) src_burst = ($urandom_range(0, 3) == 0);
  endtask

  // Hold off the input until every outstanding result is back
  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_grays.size() != 0) @(posedge clk);
  endtask

  // Fill the rest of the current frame; pixels in [base, base+span]
  task automatic load_frame(input int base, input int span, input int read_pct);
    while (!readout_open) begin
      if ($urandom_range(0, 99) < read_pct)
        send_beat(CMD_READ, 16'($urandom));
      else
        send_beat(CMD_LOAD, 16'(base + $urandom_range(0, span)));
    end
  endtask

  // Read the whole frame back, with some dropped loads mixed in
  task automatic read_frame(input int load_pct, input bit pause_midway);
    bit paused;
    paused = 1'b0;
    while (readout_open) begin
      if ($urandom_range(0, 99) < load_pct)
        send_beat(CMD_LOAD, 16'($urandom));
      else
        send_beat(CMD_READ, 16'($urandom));
      if (pause_midway && !paused && read_idx == PIXELS / 2) begin
        paused = 1'b1;
        pause_until_drained();
      end
    end
  endtask

  // Reads right after reset: no frame yet, so gray 0 with ready low
  task automatic test_reads_before_frame();
    repeat (3) send_beat(CMD_READ, 16'hFFFF);
    send_beat(CMD_READ, 16'h0000);
    pause_until_drained();
  endtask

  // Flat frame: zero range gives gray 0 everywhere; a few early reads
  task automatic test_flat_frame();
    logic [PIX_W-1:0] flat;
    flat = 16'hA55A;
    repeat (5) send_beat(CMD_LOAD, flat);
    send_beat(CMD_READ, 16'h0000);
    load_frame(int'(flat), 0, 1);
    // loads during readout must be dropped
    send_beat(CMD_LOAD, 16'h0000);
    send_beat(CMD_LOAD, 16'hFFFF);
    read_frame(2, 1'b1);
    pause_until_drained();
  endtask

  // Full-scale frame: both pixel extremes, so gray spans 0..254
  task automatic test_full_scale_frame();
    send_beat(CMD_LOAD, 16'h0000);
    send_beat(CMD_LOAD, 16'hFFFF);
    send_beat(CMD_LOAD, 16'h00FF);
    send_beat(CMD_LOAD, 16'hFF00);
    send_beat(CMD_LOAD, 16'h7FFF);
    send_beat(CMD_LOAD, 16'h8000);
    load_frame(0, 16'hFFFF, 1);
    read_frame(2, 1'b0);
    pause_until_drained();
  endtask

  // Narrow range: small divisors exercise quotient rounding
  task automatic test_narrow_range_frame();
    int span;
    int base;
    span = $urandom_range(1, 900);
    base = $urandom_range(0, 16'hFFFF - span);
    load_frame(base, span, 1);
    read_frame(2, 1'b0);
  endtask

  // Result sink with random back-pressure, checks each beat in order
  initial begin
    int         stall;
    gray_beat_t exp_beat;
    @(posedge rst_n);
    forever begin
      stall = sink_burst ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      grays_checked++;
      if (grays_checked % 128 == 0) sink_burst = ($urandom_range(0, 3) == 0);
      if (expected_grays.size() == 0) begin
        $error("unexpected result beat: gray %0d last %0b ready %0b",
               out_tdata, out_tlast, out_tuser);
        mismatches++;
      end else begin
        exp_beat = expected_grays.pop_front();
        if (out_tdata !== exp_beat.gray) begin
          $error("gray_level: expected %0d, got %0d", exp_beat.gray, out_tdata);
          mismatches++;
        end
        if (out_tlast !== exp_beat.last) begin
          $error("last_of_frame: expected %0b, got %0b", exp_beat.last, out_tlast);
          mismatches++;
        end
        if (out_tuser !== exp_beat.ready) begin
          $error("ready_res: expected %0b, got %0b", exp_beat.ready, out_tuser);
          mismatches++;
        end
      end
    end
  end

  // Test sequence
  initial begin
    int drain_wait;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reads_before_frame();
    test_flat_frame();
    test_full_scale_frame();
    test_narrow_range_frame();

    // Let the last results come back, then allow a little settling time
    in_tvalid  <= 1'b0;
    drain_wait = 0;
    while (expected_grays.size() != 0 && drain_wait < 2000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (30) @(posedge clk);
    if (expected_grays.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_grays.size());
      mismatches++;
    end

    $display("Run covered %0d pixel loads (%0d dropped in readout), %0d reads,",
             loads_taken, loads_dropped, reads_taken);
    $display("%0d full frames read out and %0d result beats checked.",
             frames_read, grays_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #60_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
